// ===== hw/rtl/pnid_pkg.sv =====
`default_nettype none

package pnid_pkg;

   localparam int LANES      = 16;
   localparam int LANE_IDX_W = 4;
   localparam int CODE_W     = 4;
   localparam int WORD_W     = LANES * CODE_W;
   localparam int POS_W      = 13;
   localparam int START_W    = 16;
   localparam int LEN_W      = 17;
   localparam int CNT_W      = 17;
   localparam int POP_W      = 5;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;

   localparam logic [CODE_W-1:0] GAP_CODE = 4'hF;
   localparam logic [CNT_W-1:0]  ACC_MAX  = 17'h1FFFF;
   localparam logic [CNT_W-1:0]  FRAC_ONE = 17'h10000;

   // register select is paddr bit 2
   localparam logic REG_START  = 1'b0;
   localparam logic REG_LENGTH = 1'b1;

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic compared;
      logic match;
   } lane_flags_type;

   typedef struct packed {
      logic      done;
      count_type match_total;
      count_type compared_total;
   } run_type;

   typedef struct packed {
      count_type match_total;
      count_type compared_total;
      count_type identity_fraction;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pnid_if.sv =====
`default_nettype none

interface pnid_req_if;
   logic                         valid;
   logic                         ready;
   logic [pnid_pkg::WORD_W-1:0]  word_a;
   logic [pnid_pkg::WORD_W-1:0]  word_b;
   logic                         last_word;

   modport source (output valid, output word_a, output word_b, output last_word,
                   input ready);
   modport sink   (input valid, input word_a, input word_b, input last_word,
                   output ready);
endinterface

interface pnid_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pnid_pkg::CNT_W-1:0]  match_total;
   logic [pnid_pkg::CNT_W-1:0]  compared_total;
   logic [pnid_pkg::CNT_W-1:0]  identity_fraction;

   modport source (output valid, output match_total, output compared_total,
                   output identity_fraction, input ready);
   modport sink   (input valid, input match_total, input compared_total,
                   input identity_fraction, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pnid_lane.sv =====
`default_nettype none

module pnid_lane (
   input  logic [pnid_pkg::CODE_W-1:0]  code_a,
   input  logic [pnid_pkg::CODE_W-1:0]  code_b,
   input  logic [pnid_pkg::LEN_W-1:0]   position,
   input  logic [pnid_pkg::START_W-1:0] start_pos,
   input  logic [pnid_pkg::LEN_W-1:0]   limit,
   output pnid_pkg::lane_flags_type     flags
);

   logic in_range;
   logic both_gap;

   always_comb begin
      in_range = (position >= pnid_pkg::LEN_W'(start_pos)) && (position < limit);
      both_gap = (code_a == pnid_pkg::GAP_CODE) && (code_b == pnid_pkg::GAP_CODE);
      flags.compared = in_range && !both_gap;
      flags.match    = in_range && !both_gap && (code_a == code_b);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pnid_merge.sv =====
`default_nettype none

module pnid_merge (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       clear,
   input  logic                                       in_valid,
   input  logic                                       in_last,
   input  pnid_pkg::lane_flags_type [pnid_pkg::LANES-1:0] flags,
   output pnid_pkg::run_type                          run
);

   logic [pnid_pkg::CNT_W-1:0] match_acc_ff, match_acc_in;
   logic [pnid_pkg::CNT_W-1:0] comp_acc_ff,  comp_acc_in;
   logic [pnid_pkg::POP_W-1:0] pop_match, pop_comp;
   logic [pnid_pkg::CNT_W:0]   sum_match, sum_comp;
   logic [pnid_pkg::CNT_W-1:0] sat_match, sat_comp;

   always_comb begin
      pop_match = '0;
      pop_comp  = '0;
      for (int i = 0; i < pnid_pkg::LANES; i++) begin
         pop_match = pop_match + pnid_pkg::POP_W'(flags[i].match);
         pop_comp  = pop_comp  + pnid_pkg::POP_W'(flags[i].compared);
      end
      sum_match = {1'b0, match_acc_ff} + (pnid_pkg::CNT_W+1)'(pop_match);
      sum_comp  = {1'b0, comp_acc_ff}  + (pnid_pkg::CNT_W+1)'(pop_comp);
      sat_match = sum_match[pnid_pkg::CNT_W] ? pnid_pkg::ACC_MAX
                                             : sum_match[pnid_pkg::CNT_W-1:0];
      sat_comp  = sum_comp[pnid_pkg::CNT_W]  ? pnid_pkg::ACC_MAX
                                             : sum_comp[pnid_pkg::CNT_W-1:0];

      match_acc_in = match_acc_ff;
      comp_acc_in  = comp_acc_ff;
      if (clear) begin
         match_acc_in = '0;
         comp_acc_in  = '0;
      end else if (in_valid) begin
         // a last word hands its totals off and starts a fresh run
         match_acc_in = in_last ? '0 : sat_match;
         comp_acc_in  = in_last ? '0 : sat_comp;
      end

      run.done           = in_valid && in_last;
      run.match_total    = sat_match;
      run.compared_total = sat_comp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_acc_ff <= '0;
         comp_acc_ff  <= '0;
      end else begin
         match_acc_ff <= match_acc_in;
         comp_acc_ff  <= comp_acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pnid_div.sv =====
`default_nettype none

module pnid_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pnid_pkg::run_type    run,
   input  logic                 take,
   output logic                 busy,
   output logic                 result_valid,
   output pnid_pkg::result_type result
);

   localparam int STEP_W = $clog2(pnid_pkg::CNT_W + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          cnt_ff, cnt_in;
   logic [pnid_pkg::CNT_W:0]   rem_ff, rem_in;
   logic [pnid_pkg::CNT_W-1:0] den_ff, den_in;
   logic [pnid_pkg::CNT_W-1:0] quo_ff, quo_in;
   logic [pnid_pkg::CNT_W-1:0] match_ff, match_in;
   logic                       ge;
   logic [pnid_pkg::CNT_W:0]   diff;

   // restoring division of match * 2^16 by compared, one quotient bit a cycle;
   // match never exceeds compared, so the remainder after each step stays below the divisor
   always_comb begin
      ge   = rem_ff >= {1'b0, den_ff};
      diff = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      match_in = match_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (run.done) begin
               rem_in   = {1'b0, run.match_total};
               den_in   = run.compared_total;
               match_in = run.match_total;
               quo_in   = '0;
               cnt_in   = STEP_W'(pnid_pkg::CNT_W);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            quo_in = {quo_ff[pnid_pkg::CNT_W-2:0], ge};
            rem_in = {diff[pnid_pkg::CNT_W-1:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      match_ff <= match_in;
   end

   always_comb begin
      busy                     = state_ff != ST_IDLE;
      result_valid             = state_ff == ST_HOLD;
      result.match_total       = match_ff;
      result.compared_total    = den_ff;
      result.identity_fraction = (den_ff == '0) ? '0 : quo_ff;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/packed_nucleotide_identity_unit.sv =====
// After the edge that takes its last word, a result passes through the lane register,
// the divider load, 17 divider steps and the output register before it is offered.
// Throughput: one word per cycle inside a run; after a last word the input
// stalls until the 17-step serial divider has handed its result to the output
// register.
// Reset (synchronous, active high) clears both registers, the accumulators,
// the word position and all valid flags.
`default_nettype none

module packed_nucleotide_identity_unit #(
   parameter int MAX_LENGTH = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   pnid_req_if.sink                      req_chan,
   pnid_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pnid_pkg::ADDR_W-1:0]   paddr,
   input  logic [pnid_pkg::DATA_W-1:0]   pwdata,
   output logic [pnid_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [pnid_pkg::START_W-1:0] start_ff, start_in;
   logic [pnid_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [pnid_pkg::POS_W-1:0]   wp_ff, wp_in;
   logic [pnid_pkg::LEN_W-1:0]   limit;
   logic                         cfg_write;
   logic                         reg_sel;
   logic                         req_accept;

   pnid_pkg::lane_flags_type [pnid_pkg::LANES-1:0] lane_flags;
   pnid_pkg::lane_flags_type [pnid_pkg::LANES-1:0] s1_flags_ff;
   logic                         s1_valid_ff;
   logic                         s1_last_ff;

   pnid_pkg::run_type            run;
   pnid_pkg::result_type         div_result;
   logic                         div_busy;
   logic                         div_result_valid;
   logic                         take;

   logic                         rsp_valid_ff, rsp_valid_in;
   pnid_pkg::result_type         rsp_data_ff;

   // ---- configuration ----
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign reg_sel   = paddr[pnid_pkg::ADDR_W-1];

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      if (cfg_write) begin
         unique case (reg_sel)
            pnid_pkg::REG_START:  start_in = pwdata[pnid_pkg::START_W-1:0];
            pnid_pkg::REG_LENGTH: len_in   = pwdata[pnid_pkg::LEN_W-1:0];
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         pnid_pkg::REG_START:  prdata = pnid_pkg::DATA_W'(start_ff);
         pnid_pkg::REG_LENGTH: prdata = pnid_pkg::DATA_W'(len_ff);
         default:              prdata = '0;
      endcase
   end

   assign limit = (int'(len_ff) > MAX_LENGTH) ? pnid_pkg::LEN_W'(MAX_LENGTH) : len_ff;

   // ---- input side and word position ----
   assign req_chan.ready = !div_busy && !(s1_valid_ff && s1_last_ff);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      wp_in = wp_ff;
      if (cfg_write) begin
         wp_in = pnid_pkg::POS_W'(start_in[pnid_pkg::START_W-1:pnid_pkg::LANE_IDX_W]);
      end else if (req_accept) begin
         wp_in = req_chan.last_word
               ? pnid_pkg::POS_W'(start_ff[pnid_pkg::START_W-1:pnid_pkg::LANE_IDX_W])
               : wp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= '0;
         wp_ff    <= '0;
      end else begin
         start_ff <= start_in;
         len_ff   <= len_in;
         wp_ff    <= wp_in;
      end
   end

   // ---- lanes: one nibble position each ----
   for (genvar i = 0; i < pnid_pkg::LANES; i++) begin : g_lane
      pnid_lane u_lane (
         .code_a    (req_chan.word_a[i*pnid_pkg::CODE_W +: pnid_pkg::CODE_W]),
         .code_b    (req_chan.word_b[i*pnid_pkg::CODE_W +: pnid_pkg::CODE_W]),
         .position  ({wp_ff, pnid_pkg::LANE_IDX_W'(i)}),
         .start_pos (start_ff),
         .limit     (limit),
         .flags     (lane_flags[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s1_flags_ff <= '0;
      end else begin
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            s1_last_ff  <= req_chan.last_word;
            s1_flags_ff <= lane_flags;
         end
      end
   end

   // ---- merge and divide ----
   pnid_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .clear    (cfg_write),
      .in_valid (s1_valid_ff),
      .in_last  (s1_last_ff),
      .flags    (s1_flags_ff),
      .run      (run)
   );

   pnid_div u_div (
      .clock        (clock),
      .reset        (reset),
      .run          (run),
      .take         (take),
      .busy         (div_busy),
      .result_valid (div_result_valid),
      .result       (div_result)
   );

   // ---- output register ----
   assign take = div_result_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= div_result;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.match_total       = rsp_data_ff.match_total;
   assign rsp_chan.compared_total    = rsp_data_ff.compared_total;
   assign rsp_chan.identity_fraction = rsp_data_ff.identity_fraction;

   // ---- checks ----
   a_no_word_while_dividing: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !div_busy)
      else $error("word taken while divider busy");

   a_match_le_compared: assert property (@(posedge clock) disable iff (reset)
      run.match_total <= run.compared_total)
      else $error("match count above compared count");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.identity_fraction <= pnid_pkg::FRAC_ONE))
      else $error("identity fraction above one");

   a_cfg_restarts_run: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=>
         (wp_ff == pnid_pkg::POS_W'(start_ff[pnid_pkg::START_W-1:pnid_pkg::LANE_IDX_W])))
      else $error("register write did not reload word position");

endmodule

`default_nettype wire

// ===== tb/sv/tb_packed_nucleotide_identity_unit.sv =====
`timescale 1ns / 100ps

module tb_packed_nucleotide_identity_unit;

   localparam int MAX_LEN    = 65536;
   localparam int SETTLE_CYC = 30;
   localparam logic [pnid_pkg::WORD_W-1:0] ALL_GAPS = {pnid_pkg::WORD_W{1'b1}};
   localparam logic [pnid_pkg::WORD_W-1:0] NO_GAPS  = 64'h0123_4567_89AB_CDE0;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [pnid_pkg::ADDR_W-1:0] paddr;
   logic [pnid_pkg::DATA_W-1:0] pwdata;
   logic [pnid_pkg::DATA_W-1:0] prdata;
   logic pready;

   pnid_req_if req_bus ();
   pnid_rsp_if rsp_bus ();

   packed_nucleotide_identity_unit #(.MAX_LENGTH(MAX_LEN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // shadow of the block's registers and run state
   logic [pnid_pkg::START_W-1:0] cfg_start;
   logic [pnid_pkg::LEN_W-1:0]   cfg_length;
   logic [pnid_pkg::POS_W-1:0]   word_pos;
   pnid_pkg::count_type          match_acc;
   pnid_pkg::count_type          compared_acc;

   pnid_pkg::result_type pending_identity[$];
   int  mismatch_count;
   bit  stall_on;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!stall_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void report_mismatch(string what, longint exp_v, longint act_v);
      if (mismatch_count < 10)
         $display("mismatch %0s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
      mismatch_count++;
   endfunction

   function automatic pnid_pkg::count_type sat_sum(pnid_pkg::count_type acc,
                                                   int unsigned inc);
      int unsigned s;
      s = acc + inc;
      return (s > pnid_pkg::ACC_MAX) ? pnid_pkg::ACC_MAX : pnid_pkg::count_type'(s);
   endfunction

   function automatic void restart_run();
      word_pos     = pnid_pkg::POS_W'(cfg_start / pnid_pkg::LANES);
      match_acc    = '0;
      compared_acc = '0;
   endfunction

   // per-word tally of matches and compared positions; queues a result on last word
   function automatic void tally_word_pair(logic [pnid_pkg::WORD_W-1:0] a,
                                           logic [pnid_pkg::WORD_W-1:0] b,
                                           logic last);
      int unsigned lim, base, pos, mcnt, ccnt;
      logic [pnid_pkg::CODE_W-1:0] ca, cb;
      longint unsigned num;
      pnid_pkg::result_type r;
      lim  = (cfg_length > MAX_LEN) ? MAX_LEN : cfg_length;
      base = int'(word_pos) * pnid_pkg::LANES;
      mcnt = 0;
      ccnt = 0;
      for (int i = 0; i < pnid_pkg::LANES; i++) begin
         pos = base + i;
         ca  = a[pnid_pkg::CODE_W*i +: pnid_pkg::CODE_W];
         cb  = b[pnid_pkg::CODE_W*i +: pnid_pkg::CODE_W];
         if (pos < cfg_start || pos >= lim) continue;
         if (ca == pnid_pkg::GAP_CODE && cb == pnid_pkg::GAP_CODE) continue;
         ccnt++;
         if (ca == cb) mcnt++;
      end
      match_acc    = sat_sum(match_acc, mcnt);
      compared_acc = sat_sum(compared_acc, ccnt);
      word_pos     = word_pos + 1'b1;
      if (last) begin
         num = longint'(match_acc) << 16;
         r.match_total       = match_acc;
         r.compared_total    = compared_acc;
         r.identity_fraction = (compared_acc == 0)
                             ? '0 : pnid_pkg::count_type'(num / compared_acc);
         pending_identity.push_back(r);
         restart_run();
      end
   endfunction

   // one word pair; returns at the edge it was taken, valid still high
   task automatic send_word(logic [pnid_pkg::WORD_W-1:0] a, logic [pnid_pkg::WORD_W-1:0] b,
                            logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.word_a    <= a;
      req_bus.word_b    <= b;
      req_bus.last_word <= last;
      do @(posedge clock); while (!req_bus.ready);
      tally_word_pair(a, b, last);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_identity.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      drain_results();
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [pnid_pkg::DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= pnid_pkg::ADDR_W'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == 0) begin
         cfg_start = value[pnid_pkg::START_W-1:0];
         restart_run();
      end else if (idx == 1) begin
         cfg_length = value[pnid_pkg::LEN_W-1:0];
         restart_run();
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(int idx, output logic [pnid_pkg::DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= pnid_pkg::ADDR_W'(idx * 4);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits are junk to exercise register masking
   task automatic program_window(int unsigned start, int unsigned length);
      logic [pnid_pkg::DATA_W-1:0] rd;
      wait_idle();
      csr_write(0, {16'($urandom), 16'(start)});
      csr_write(1, {15'($urandom), 17'(length)});
      csr_read(0, rd);
      if (rd !== pnid_pkg::DATA_W'(cfg_start))
         report_mismatch("start readback", cfg_start, rd);
      csr_read(1, rd);
      if (rd !== pnid_pkg::DATA_W'(cfg_length))
         report_mismatch("length readback", cfg_length, rd);
   endtask

   // gaps are common, b often mirrors a
   task automatic make_pair(output logic [pnid_pkg::WORD_W-1:0] a,
                            output logic [pnid_pkg::WORD_W-1:0] b);
      logic [pnid_pkg::CODE_W-1:0] ca, cb;
      int r;
      if ($urandom_range(0, 9) == 0) begin
         a = {$urandom, $urandom};
         b = {$urandom, $urandom};
      end else begin
         for (int i = 0; i < pnid_pkg::LANES; i++) begin
            ca = ($urandom_range(0, 9) < 3) ? pnid_pkg::GAP_CODE
                                            : pnid_pkg::CODE_W'($urandom);
            r  = $urandom_range(0, 9);
            if (r < 5) cb = ca;
            else if (r < 7) cb = pnid_pkg::GAP_CODE;
            else cb = pnid_pkg::CODE_W'($urandom);
            a[pnid_pkg::CODE_W*i +: pnid_pkg::CODE_W] = ca;
            b[pnid_pkg::CODE_W*i +: pnid_pkg::CODE_W] = cb;
         end
      end
   endtask

   task automatic test_directed_cases();
      logic [pnid_pkg::WORD_W-1:0] a, b;
      stall_on = 1'b1;
      // registers still at reset: length 0, nothing in range
      send_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      program_window(0, 65536);
      send_word(NO_GAPS, NO_GAPS, 1'b1);
      send_word(ALL_GAPS, ALL_GAPS, 1'b1);
      send_word(ALL_GAPS, '0, 1'b1);
      send_word('0, ALL_GAPS, 1'b1);
      send_word(NO_GAPS, NO_GAPS ^ 64'hF000_0000_0000_0001, 1'b1);
      make_pair(a, b);
      send_word(a, b, 1'b0);
      make_pair(a, b);
      send_word(a, b, 1'b0);
      make_pair(a, b);
      send_word(a, b, 1'b1);
      // register write in the middle of a run drops the partial counts
      send_word(NO_GAPS, NO_GAPS, 1'b0);
      send_word(NO_GAPS, ~NO_GAPS, 1'b0);
      program_window(0, 65536);
      send_word(NO_GAPS, NO_GAPS, 1'b1);
      // single word with both edges masked
      program_window(3, 10);
      make_pair(a, b);
      send_word(a, b, 1'b1);
      program_window(100, 50);
      send_word(NO_GAPS, NO_GAPS, 1'b0);
      send_word(NO_GAPS, NO_GAPS, 1'b1);
      // length past the hard limit, start near the top
      program_window(65530, 131071);
      send_word(NO_GAPS, NO_GAPS, 1'b0);
      send_word(NO_GAPS, NO_GAPS, 1'b1);
      program_window(65535, 65536);
      send_word(NO_GAPS, NO_GAPS, 1'b1);
      program_window(0, 1);
      send_word(NO_GAPS, NO_GAPS, 1'b1);
   endtask

   task automatic test_random_runs();
      logic [pnid_pkg::WORD_W-1:0] a, b;
      int unsigned start, length;
      int sent, run_len;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin start = 0; length = 65536; end
            1: begin start = 65535; length = 131071; end
            2: begin start = 0; length = 0; end
            3: begin start = 0; length = $urandom_range(1, 200); end
            4: begin start = 65504; length = 65536; end
            default: begin
               start  = $urandom_range(0, 65535);
               length = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                    : start + $urandom_range(0, 300);
            end
         endcase
         program_window(start, length);
         stall_on = (phase % 3) != 2;
         sent = 0;
         while (sent < 100) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) begin
               make_pair(a, b);
               send_word(a, b, k == run_len - 1);
            end
            sent += run_len;
            if ($urandom_range(0, 15) == 0) drain_results();
         end
      end
      stall_on = 1'b1;
   endtask

   // result side: random back-pressure and in-order compare
   initial begin
      int hold_left;
      pnid_pkg::result_type want;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               if (pending_identity.size() == 0) begin
                  report_mismatch("unexpected word, match_total", -1, rsp_bus.match_total);
               end else begin
                  want = pending_identity.pop_front();
                  if (rsp_bus.match_total !== want.match_total)
                     report_mismatch("match_total", want.match_total, rsp_bus.match_total);
                  if (rsp_bus.compared_total !== want.compared_total)
                     report_mismatch("compared_total", want.compared_total,
                                     rsp_bus.compared_total);
                  if (rsp_bus.identity_fraction !== want.identity_fraction)
                     report_mismatch("identity_fraction", want.identity_fraction,
                                     rsp_bus.identity_fraction);
               end
            end
            if (hold_left > 0) begin
               rsp_bus.ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
               hold_left = pick_gap();
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      stall_on       = 1'b1;
      cfg_start      = '0;
      cfg_length     = '0;
      restart_run();
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.word_a    <= '0;
      req_bus.word_b    <= '0;
      req_bus.last_word <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_runs();

      wait_idle();
      if (mismatch_count == 0 && pending_identity.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
